// ===== rtl/acrr_pkg.sv =====
// Shared types and constants of the round-robin descriptor cache.
package acrr_pkg;

  localparam int unsigned SlotsDef   = 8;
  localparam int unsigned KeyBitsDef = 64;

  localparam int unsigned KeyW    = 64;
  localparam int unsigned HandleW = 32;
  localparam int unsigned DimW    = 16;
  localparam int unsigned FmtW    = 8;

  localparam int unsigned TdataInW  = 136;
  localparam int unsigned TdataOutW = 104;
  localparam int unsigned TuserOutW = 2;

  typedef enum logic {
    REQ_LOOKUP = 1'b0,
    REQ_PUT    = 1'b1
  } req_type_e;

  // Descriptor held in one slot.
  typedef struct packed {
    logic [FmtW-1:0]    fmt;
    logic [DimW-1:0]    height;
    logic [DimW-1:0]    width;
    logic [HandleW-1:0] handle;
  } desc_t;

  typedef struct packed {
    req_type_e       req_type;
    logic [KeyW-1:0] key;
    desc_t           desc;
  } req_t;

  typedef struct packed {
    logic               hit;
    desc_t              desc;
    logic               rel_valid;
    logic [HandleW-1:0] rel_handle;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic look;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_full;
  } stat_t;

endpackage

// ===== rtl/acrr_ctrl.sv =====
// Request sequencer of the round-robin descriptor cache.
module acrr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  input  logic           m_tready_i,
  input  acrr_pkg::stat_t stat_i,
  output acrr_pkg::cmd_t  cmd_o
);
  import acrr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   can_commit;

  assign can_commit = !stat_i.out_full || m_tready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (can_commit) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_tready_o     = (state_q == ST_IDLE);
  assign cmd_o.capture  = (state_q == ST_IDLE) && s_tvalid_i;
  assign cmd_o.look     = (state_q == ST_LOOK);
  assign cmd_o.commit   = (state_q == ST_DONE) && can_commit;

endmodule

// ===== rtl/acrr_dpath.sv =====
// Slot storage, key compare, slot selection and result register of the cache.
module acrr_dpath #(
  parameter int unsigned SLOTS    = acrr_pkg::SlotsDef,
  parameter int unsigned KEY_BITS = acrr_pkg::KeyBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  acrr_pkg::req_t  req_i,
  input  acrr_pkg::cmd_t  cmd_i,
  output acrr_pkg::stat_t stat_o,
  input  logic            m_tready_i,
  output logic            m_tvalid_o,
  output acrr_pkg::res_t  res_o
);
  import acrr_pkg::*;

  localparam int unsigned IdxW = $clog2(SLOTS);

  // Valid bits and keys are flops so that every slot is compared at once.
  logic [SLOTS-1:0]    valid_q;
  logic [KEY_BITS-1:0] key_q [SLOTS];
  // Descriptors are read at one address per request.
  desc_t               mem [SLOTS];
  logic [IdxW-1:0]     evict_ptr_q, evict_ptr_d;

  req_t            req_q;
  logic [SLOTS-1:0] match_q, match_d;
  logic            hit_q, full_q;
  logic [IdxW-1:0] wr_idx_q;
  desc_t           rd_q;

  logic [IdxW-1:0] hit_idx, free_idx, wr_idx_d, rd_idx;
  logic            hit_any, free_any, do_write;
  res_t            res_q, res_d;
  logic            out_valid_q;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match_d[i] = valid_q[i] && (key_q[i] == req_i.key[KEY_BITS-1:0]);
    end
  end

  // Lowest-numbered matching slot and lowest-numbered empty slot.
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match_q[i]) hit_idx = IdxW'(i);
      if (!valid_q[i]) free_idx = IdxW'(i);
    end
  end

  assign hit_any  = |match_q;
  assign free_any = ~&valid_q;
  assign wr_idx_d = hit_any ? hit_idx : (free_any ? free_idx : evict_ptr_q);
  assign rd_idx   = hit_any ? hit_idx : evict_ptr_q;

  assign do_write = (req_q.req_type == REQ_PUT) && (req_q.desc.handle != '0);

  assign evict_ptr_d = (evict_ptr_q == IdxW'(SLOTS - 1)) ? '0 : evict_ptr_q + IdxW'(1);

  always_comb begin
    res_d = '0;
    if (req_q.req_type == REQ_LOOKUP) begin
      res_d.hit = hit_q;
      if (hit_q) res_d.desc = rd_q;
    end else if (do_write) begin
      res_d.rel_valid = hit_q || full_q;
      if (hit_q || full_q) res_d.rel_handle = rd_q.handle;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q   <= req_i;
      match_q <= match_d;
    end
    if (cmd_i.look) begin
      hit_q    <= hit_any;
      full_q   <= !free_any;
      wr_idx_q <= wr_idx_d;
      rd_q     <= mem[rd_idx];
    end
    if (cmd_i.commit && do_write) begin
      mem[wr_idx_q]   <= req_q.desc;
      key_q[wr_idx_q] <= req_q.key[KEY_BITS-1:0];
    end
    if (cmd_i.commit) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      evict_ptr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit && do_write) begin
        valid_q[wr_idx_q] <= 1'b1;
        if (!hit_q && full_q) evict_ptr_q <= evict_ptr_d;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.out_full = out_valid_q;
  assign m_tvalid_o      = out_valid_q;
  assign res_o           = res_q;

  // Keys of valid slots stay unique, so at most one slot can match.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.look |-> $onehot0(match_q))
    else $error("more than one valid slot matches the key");

  // The replacement pointer only moves once every slot is in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(&valid_q) |=> $stable(evict_ptr_q))
    else $error("replacement pointer moved while an empty slot existed");

  // Slots are never invalidated.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (valid_q & $past(valid_q)) == $past(valid_q))
    else $error("a valid slot was dropped");

  // A new result never overwrites one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cmd_i.commit |-> (!out_valid_q || m_tready_i))
    else $error("result register overwritten before it was taken");

endmodule

// ===== rtl/assoc_cache_round_robin.sv =====
// Top level of the fully associative image descriptor cache with round-robin replacement.
//
//   Channel  Direction  Contents
//   s_axis   in         one request: lookup or put of a keyed image descriptor
//   m_axis   out        one response per request: hit data or released handle
//
// Each request passes through the sequencer states in order: the key is compared
// against every valid slot in the accept state, the winning slot index and its descriptor
// are read in ST_LOOK, and the slot update and response register load happen in ST_DONE.
// The descriptor store has one read port, which sets this sequence.
// The response register lets the next request be accepted while a response waits.
// If the previous response is still not taken, ST_DONE waits for it.
// Reset clears the valid bits, the replacement pointer and the sequencer at once;
// there is no clearing pass over the stored keys and descriptors.
module assoc_cache_round_robin #(
  parameter int unsigned SLOTS    = acrr_pkg::SlotsDef,
  parameter int unsigned KEY_BITS = acrr_pkg::KeyBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Request channel.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // key[63:0], buf_handle[95:64], img_width[111:96], img_height[127:112],
  // color_format[135:128]
  input  logic [acrr_pkg::TdataInW-1:0]  s_axis_tdata,
  // req_type[0]
  input  logic                           s_axis_tuser,
  // Response channel.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_handle[31:0], out_width[47:32], out_height[63:48], out_format[71:64],
  // released_handle[103:72]
  output logic [acrr_pkg::TdataOutW-1:0] m_axis_tdata,
  // hit[0], released_valid[1]
  output logic [acrr_pkg::TuserOutW-1:0] m_axis_tuser
);
  import acrr_pkg::*;

  req_t  req;
  res_t  res;
  cmd_t  cmd;
  stat_t stat;

  // Unpack the request fields from the stream payload.
  assign req.req_type    = req_type_e'(s_axis_tuser);
  assign req.key         = s_axis_tdata[63:0];
  assign req.desc.handle = s_axis_tdata[95:64];
  assign req.desc.width  = s_axis_tdata[111:96];
  assign req.desc.height = s_axis_tdata[127:112];
  assign req.desc.fmt    = s_axis_tdata[135:128];

  acrr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tready_i (m_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  acrr_dpath #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .res_o      (res)
  );

  // Pack the response fields, lowest field in the lowest bits.
  assign m_axis_tdata = {res.rel_handle, res.desc.fmt, res.desc.height,
                         res.desc.width, res.desc.handle};
  assign m_axis_tuser = {res.rel_valid, res.hit};

endmodule
